// File: hw/rtl/wsfe_pkg.sv
package wsfe_pkg;

   // fixed field widths
   localparam int SAMPLE_W  = 16;
   localparam int BIN_W     = 24;
   localparam int FRAME_W   = 16;
   localparam int INDEX_W   = 6;
   localparam int HOP_W     = 9;
   localparam int FILL_W    = 7;
   localparam int RING_AW   = 6;
   localparam int RING_DEPTH = 64;
   localparam int PROD_W    = SAMPLE_W + BIN_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int TW_W      = ACC_W - 15;
   localparam int SUM_W     = TW_W + 1;
   localparam logic [HOP_W-1:0] HOP_RESET = 9'd32;

   // fixed-point constants, Q30
   localparam longint PI_HALF_Q30 = 64'd1686629713;
   localparam longint C054_Q30    = 64'd579820585;
   localparam longint C046_Q30    = 64'd493921239;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_MUL,
      ST_LD_WR,
      ST_BF_RD,
      ST_BF_LAT,
      ST_BF_M1,
      ST_BF_M2,
      ST_BF_M3,
      ST_BF_M4,
      ST_BF_M5,
      ST_BF_RND,
      ST_BF_WA,
      ST_BF_WB,
      ST_OUT_RD,
      ST_OUT_HOLD
   } state_type;

endpackage

// File: hw/rtl/wsfe_if.sv
interface wsfe_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [wsfe_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface wsfe_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic        [wsfe_pkg::FRAME_W-1:0]   frame_number;
   logic        [wsfe_pkg::INDEX_W-1:0]   bin_index;
   logic signed [wsfe_pkg::BIN_W-1:0]     bin_real;
   logic signed [wsfe_pkg::BIN_W-1:0]     bin_imag;
   logic                                   last_bin;

   modport source (output valid, output frame_number, output bin_index, output bin_real,
                   output bin_imag, output last_bin, input ready);
   modport sink   (input valid, input frame_number, input bin_index, input bin_real,
                   input bin_imag, input last_bin, output ready);
endinterface

// File: hw/rtl/wsfe_ram.sv
module wsfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write one entry, register both reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// File: hw/rtl/windowed_stft_frame_engine.sv
// Non-framing sample: accepted while the sequencer stays in idle, so ready stays high.
// Framing sample: ready drops while the N samples are windowed (read, multiply,
// write) and the (N/2)*log2(N) butterflies run, all on one shared 16x24 multiplier.
// Bins then leave one at a time, each read from the store and then held until taken,
// N items per frame; ready returns only after the last bin of the frame has been accepted.
// Synchronous active-high reset clears the sequencer, counters and hop register
// (hop 32); sample ring and transform store hold no reset.
module windowed_stft_frame_engine #(
   parameter int FFT_POINTS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   wsfe_req_if.sink                             req_chan,
   wsfe_rsp_if.source                           rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [wsfe_pkg::HOP_W-1:0]           csr_wr_data
);

   localparam int LOG2  = $clog2(FFT_POINTS);
   localparam int HB    = LOG2 - 1;
   localparam int STG_W = $clog2(LOG2);
   localparam int HALF  = FFT_POINTS / 2;
   localparam int WQ    = FFT_POINTS - 1;
   localparam int TQ4   = 4 * FFT_POINTS;
   localparam int SW    = 2 * wsfe_pkg::BIN_W;
   localparam longint MASK40 = (64'd1 << 40) - 64'd1;
   localparam longint unsigned PI_HALF_Q30_U = wsfe_pkg::PI_HALF_Q30;

   // ---------------- elaboration-time tables ----------------
   function automatic longint unsigned taylor_div(input longint unsigned t, input int k);
      longint unsigned r;
      case (k)
         1: r = t / 2;
         2: r = t / 12;
         3: r = t / 30;
         4: r = t / 56;
         5: r = t / 90;
         6: r = t / 132;
         7: r = t / 182;
         8: r = t / 240;
         9: r = t / 306;
         default: r = t / 380;
      endcase
      return r;
   endfunction

   function automatic longint taylor_cos(input longint unsigned r);
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      x2 = (r * r) >> 30;
      term = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (int k = 1; k <= 10; k++) begin
         term = taylor_div((term * x2) >> 30, k);
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      return sum;
   endfunction

   // fold a quarter-turn position into the first quadrant, sign in bit 40
   function automatic longint fold_pos(input longint pos_in, input longint q);
      longint pos;
      longint neg;
      pos = pos_in;
      neg = 0;
      if (pos > 2 * q) pos = 4 * q - pos;
      if (pos > q) begin
         pos = 2 * q - pos;
         neg = 64'd1 << 40;
      end
      return pos | neg;
   endfunction

   function automatic longint cos_win(input int n);
      longint f;
      longint c;
      f = fold_pos((n == WQ) ? 0 : 4 * n, WQ);
      c = taylor_cos(longint'((PI_HALF_Q30_U * (f & MASK40)) / WQ));
      return f[40] ? -c : c;
   endfunction

   function automatic longint cos_re(input int n);
      longint f;
      longint c;
      f = fold_pos(4 * n, FFT_POINTS);
      c = taylor_cos(longint'((PI_HALF_Q30_U * (f & MASK40)) / FFT_POINTS));
      return f[40] ? -c : c;
   endfunction

   // wrap the position into one full turn before folding
   function automatic longint cos_im(input int n);
      longint f;
      longint c;
      f = fold_pos((16 * n + 12 * FFT_POINTS) % (16 * FFT_POINTS), TQ4);
      c = taylor_cos(longint'((PI_HALF_Q30_U * (f & MASK40)) / TQ4));
      return f[40] ? -c : c;
   endfunction

   function automatic int win_coef(input int n);
      longint v;
      v = ((wsfe_pkg::C054_Q30 << 30) - wsfe_pkg::C046_Q30 * cos_win(n) + (64'sd1 << 44)) >>> 45;
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      return int'(v);
   endfunction

   function automatic int q15_of(input longint c);
      longint v;
      v = (c + 64'sd16384) >>> 15;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return int'(v);
   endfunction

   logic signed [15:0] win_rom [FFT_POINTS];
   logic signed [15:0] tw_re   [HALF];
   logic signed [15:0] tw_im   [HALF];

   for (genvar g = 0; g < FFT_POINTS; g++) begin : g_win
      assign win_rom[g] = 16'(win_coef(g));
   end
   for (genvar g = 0; g < HALF; g++) begin : g_tw
      assign tw_re[g] = 16'(q15_of(cos_re(g)));
      assign tw_im[g] = 16'(q15_of(-cos_im(g)));
   end

   // ---------------- runtime helpers ----------------
   function automatic logic signed [wsfe_pkg::TW_W-1:0] rnd15(
      input logic signed [wsfe_pkg::ACC_W-1:0] a);
      logic signed [wsfe_pkg::ACC_W-1:0] t;
      t = a + wsfe_pkg::ACC_W'(16384);
      return t[wsfe_pkg::ACC_W-1:15];
   endfunction

   function automatic logic signed [wsfe_pkg::BIN_W-1:0] sat24(
      input logic signed [wsfe_pkg::SUM_W-1:0] v);
      logic signed [wsfe_pkg::BIN_W-1:0] r;
      if (v > wsfe_pkg::SUM_W'(8388607)) r = 24'sh7FFFFF;
      else if (v < -wsfe_pkg::SUM_W'(8388608)) r = 24'sh800000;
      else r = v[wsfe_pkg::BIN_W-1:0];
      return r;
   endfunction

   function automatic logic [LOG2-1:0] bit_rev(input logic [LOG2-1:0] v);
      logic [LOG2-1:0] r;
      for (int i = 0; i < LOG2; i++) r[i] = v[LOG2-1-i];
      return r;
   endfunction

   // ---------------- state ----------------
   wsfe_pkg::state_type state_ff, state_in;
   logic [wsfe_pkg::HOP_W-1:0]   hop_size_ff, hop_size_in;
   logic [wsfe_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [wsfe_pkg::HOP_W-1:0]   hop_cnt_ff, hop_cnt_in;
   logic [wsfe_pkg::RING_AW-1:0] wp_ff, wp_in;
   logic [wsfe_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [LOG2-1:0]              ld_j_ff, ld_j_in;
   logic [HB-1:0]                bf_ff, bf_in;
   logic [STG_W-1:0]             stage_ff, stage_in;
   logic [LOG2-1:0]              out_k_ff, out_k_in;

   logic signed [wsfe_pkg::BIN_W-1:0]  ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [wsfe_pkg::BIN_W-1:0]  ar_in, ai_in, br_in, bi_in;
   logic signed [wsfe_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [wsfe_pkg::ACC_W-1:0]  acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [wsfe_pkg::TW_W-1:0]   t_re_ff, t_re_in, t_im_ff, t_im_in;

   // memories
   logic [wsfe_pkg::RING_AW-1:0]  ring_rd_addr;
   logic [wsfe_pkg::SAMPLE_W-1:0] ring_rd_data;
   logic                          ring_we;
   logic                          store_we;
   logic [LOG2-1:0]               store_wr_addr, store_rd_addr_a, store_rd_addr_b;
   logic [SW-1:0]                 store_wr_data, store_rd_a, store_rd_b;

   // butterfly addressing
   logic [LOG2-1:0] half_bit, bf_ext, bf_lo, bf_ia, bf_ib, tw_shift;
   logic [HB-1:0]   tw_k;

   // shared multiplier operands
   logic signed [wsfe_pkg::SAMPLE_W-1:0] mul_a;
   logic signed [wsfe_pkg::BIN_W-1:0]    mul_b;

   logic req_fire, rsp_fire;

   // open input only in idle, offer a bin only while holding one
   assign req_chan.ready = (state_ff == wsfe_pkg::ST_IDLE);
   assign rsp_chan.valid = (state_ff == wsfe_pkg::ST_OUT_HOLD);

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign ring_we  = req_fire;

   wsfe_ram #(.WIDTH(wsfe_pkg::SAMPLE_W), .DEPTH(wsfe_pkg::RING_DEPTH)) u_ring (
      .clock     (clock),
      .wr_en     (ring_we),
      .wr_addr   (wp_ff),
      .wr_data   (req_chan.sample),
      .rd_addr_a (ring_rd_addr),
      .rd_data_a (ring_rd_data),
      .rd_addr_b (ring_rd_addr),
      .rd_data_b ()
   );

   wsfe_ram #(.WIDTH(SW), .DEPTH(FFT_POINTS)) u_store (
      .clock     (clock),
      .wr_en     (store_we),
      .wr_addr   (store_wr_addr),
      .wr_data   (store_wr_data),
      .rd_addr_a (store_rd_addr_a),
      .rd_data_a (store_rd_a),
      .rd_addr_b (store_rd_addr_b),
      .rd_data_b (store_rd_b)
   );

   // locate the pair and twiddle of the current butterfly
   always_comb begin
      half_bit = LOG2'(1) << stage_ff;
      bf_ext   = LOG2'(bf_ff);
      bf_lo    = bf_ext & (half_bit - LOG2'(1));
      bf_ia    = ((bf_ext >> stage_ff) << ({1'b0, stage_ff} + 1'b1)) | bf_lo;
      bf_ib    = bf_ia | half_bit;
      tw_shift = LOG2'(HB) - LOG2'(stage_ff);
      tw_k     = HB'(bf_lo << tw_shift);
   end

   assign ring_rd_addr    = wp_ff - wsfe_pkg::RING_AW'(FFT_POINTS)
                            + wsfe_pkg::RING_AW'(ld_j_ff);
   assign store_rd_addr_a = (state_ff == wsfe_pkg::ST_BF_RD) ? bf_ia : out_k_ff;
   assign store_rd_addr_b = bf_ib;

   // select operands for the shared multiplier
   always_comb begin
      unique case (state_ff)
         wsfe_pkg::ST_BF_M1: begin
            mul_a = tw_re[tw_k];
            mul_b = br_ff;
         end
         wsfe_pkg::ST_BF_M2: begin
            mul_a = tw_im[tw_k];
            mul_b = bi_ff;
         end
         wsfe_pkg::ST_BF_M3: begin
            mul_a = tw_re[tw_k];
            mul_b = bi_ff;
         end
         wsfe_pkg::ST_BF_M4: begin
            mul_a = tw_im[tw_k];
            mul_b = br_ff;
         end
         default: begin
            mul_a = win_rom[ld_j_ff];
            mul_b = wsfe_pkg::BIN_W'(signed'(ring_rd_data));
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // sequencer: next state, counters, store writes
   always_comb begin
      state_in    = state_ff;
      hop_size_in = csr_wr_en ? csr_wr_data : hop_size_ff;
      fill_in     = fill_ff;
      hop_cnt_in  = hop_cnt_ff;
      wp_in       = wp_ff;
      frame_in    = frame_ff;
      ld_j_in     = ld_j_ff;
      bf_in       = bf_ff;
      stage_in    = stage_ff;
      out_k_in    = out_k_ff;
      store_we      = 1'b0;
      store_wr_addr = bf_ia;
      store_wr_data = {sat24(wsfe_pkg::SUM_W'(ar_ff) + wsfe_pkg::SUM_W'(t_re_ff)),
                       sat24(wsfe_pkg::SUM_W'(ai_ff) + wsfe_pkg::SUM_W'(t_im_ff))};

      unique case (state_ff)
         wsfe_pkg::ST_IDLE: begin
            if (req_fire) begin
               wp_in = wp_ff + 1'b1;
               ld_j_in = '0;
               if (fill_ff < wsfe_pkg::FILL_W'(FFT_POINTS)) begin
                  fill_in = fill_ff + 1'b1;
                  if (fill_in == wsfe_pkg::FILL_W'(FFT_POINTS)) begin
                     hop_cnt_in = hop_size_ff;
                     state_in = wsfe_pkg::ST_LD_RD;
                  end
               end else if (hop_cnt_ff <= wsfe_pkg::HOP_W'(1)) begin
                  hop_cnt_in = hop_size_ff;
                  state_in = wsfe_pkg::ST_LD_RD;
               end else begin
                  hop_cnt_in = hop_cnt_ff - 1'b1;
               end
            end
         end
         wsfe_pkg::ST_LD_RD:  state_in = wsfe_pkg::ST_LD_MUL;
         wsfe_pkg::ST_LD_MUL: state_in = wsfe_pkg::ST_LD_WR;
         wsfe_pkg::ST_LD_WR: begin
            // store windowed sample at its bit-reversed slot
            store_we      = 1'b1;
            store_wr_addr = bit_rev(ld_j_ff);
            store_wr_data = {wsfe_pkg::BIN_W'(rnd15(wsfe_pkg::ACC_W'(prod_ff))),
                             {wsfe_pkg::BIN_W{1'b0}}};
            ld_j_in = ld_j_ff + 1'b1;
            if (ld_j_ff == LOG2'(FFT_POINTS - 1)) begin
               bf_in    = '0;
               stage_in = '0;
               state_in = wsfe_pkg::ST_BF_RD;
            end else begin
               state_in = wsfe_pkg::ST_LD_RD;
            end
         end
         wsfe_pkg::ST_BF_RD:  state_in = wsfe_pkg::ST_BF_LAT;
         wsfe_pkg::ST_BF_LAT: state_in = wsfe_pkg::ST_BF_M1;
         wsfe_pkg::ST_BF_M1:  state_in = wsfe_pkg::ST_BF_M2;
         wsfe_pkg::ST_BF_M2:  state_in = wsfe_pkg::ST_BF_M3;
         wsfe_pkg::ST_BF_M3:  state_in = wsfe_pkg::ST_BF_M4;
         wsfe_pkg::ST_BF_M4:  state_in = wsfe_pkg::ST_BF_M5;
         wsfe_pkg::ST_BF_M5:  state_in = wsfe_pkg::ST_BF_RND;
         wsfe_pkg::ST_BF_RND: state_in = wsfe_pkg::ST_BF_WA;
         wsfe_pkg::ST_BF_WA: begin
            store_we = 1'b1;
            state_in = wsfe_pkg::ST_BF_WB;
         end
         wsfe_pkg::ST_BF_WB: begin
            // write lower leg, then advance butterfly and stage
            store_we      = 1'b1;
            store_wr_addr = bf_ib;
            store_wr_data = {sat24(wsfe_pkg::SUM_W'(ar_ff) - wsfe_pkg::SUM_W'(t_re_ff)),
                             sat24(wsfe_pkg::SUM_W'(ai_ff) - wsfe_pkg::SUM_W'(t_im_ff))};
            bf_in = bf_ff + 1'b1;
            state_in = wsfe_pkg::ST_BF_RD;
            if (bf_ff == HB'(HALF - 1)) begin
               stage_in = stage_ff + 1'b1;
               if (stage_ff == STG_W'(LOG2 - 1)) begin
                  out_k_in = '0;
                  state_in = wsfe_pkg::ST_OUT_RD;
               end
            end
         end
         wsfe_pkg::ST_OUT_RD: state_in = wsfe_pkg::ST_OUT_HOLD;
         wsfe_pkg::ST_OUT_HOLD: begin
            if (rsp_fire) begin
               out_k_in = out_k_ff + 1'b1;
               if (out_k_ff == LOG2'(FFT_POINTS - 1)) begin
                  frame_in = frame_ff + 1'b1;
                  state_in = wsfe_pkg::ST_IDLE;
               end else begin
                  state_in = wsfe_pkg::ST_OUT_RD;
               end
            end
         end
      endcase
   end

   // butterfly datapath next values
   always_comb begin
      ar_in     = ar_ff;
      ai_in     = ai_ff;
      br_in     = br_ff;
      bi_in     = bi_ff;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      t_re_in   = t_re_ff;
      t_im_in   = t_im_ff;
      unique case (state_ff)
         wsfe_pkg::ST_BF_LAT: begin
            ar_in = store_rd_a[SW-1:wsfe_pkg::BIN_W];
            ai_in = store_rd_a[wsfe_pkg::BIN_W-1:0];
            br_in = store_rd_b[SW-1:wsfe_pkg::BIN_W];
            bi_in = store_rd_b[wsfe_pkg::BIN_W-1:0];
         end
         wsfe_pkg::ST_BF_M2: acc_re_in = wsfe_pkg::ACC_W'(prod_ff);
         wsfe_pkg::ST_BF_M3: acc_re_in = acc_re_ff - wsfe_pkg::ACC_W'(prod_ff);
         wsfe_pkg::ST_BF_M4: begin
            acc_im_in = wsfe_pkg::ACC_W'(prod_ff);
            t_re_in   = rnd15(acc_re_ff);
         end
         wsfe_pkg::ST_BF_M5:  acc_im_in = acc_im_ff + wsfe_pkg::ACC_W'(prod_ff);
         wsfe_pkg::ST_BF_RND: t_im_in = rnd15(acc_im_ff);
         default: ;
      endcase
   end

   // result payload straight from the store's read register
   assign rsp_chan.frame_number = frame_ff;
   assign rsp_chan.bin_index    = wsfe_pkg::INDEX_W'(out_k_ff);
   assign rsp_chan.bin_real     = store_rd_a[SW-1:wsfe_pkg::BIN_W];
   assign rsp_chan.bin_imag     = store_rd_a[wsfe_pkg::BIN_W-1:0];
   assign rsp_chan.last_bin     = (out_k_ff == LOG2'(FFT_POINTS - 1));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= wsfe_pkg::ST_IDLE;
         hop_size_ff <= wsfe_pkg::HOP_RESET;
         fill_ff     <= '0;
         hop_cnt_ff  <= '0;
         wp_ff       <= '0;
         frame_ff    <= '0;
         ld_j_ff     <= '0;
         bf_ff       <= '0;
         stage_ff    <= '0;
         out_k_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         hop_size_ff <= hop_size_in;
         fill_ff     <= fill_in;
         hop_cnt_ff  <= hop_cnt_in;
         wp_ff       <= wp_in;
         frame_ff    <= frame_in;
         ld_j_ff     <= ld_j_in;
         bf_ff       <= bf_in;
         stage_ff    <= stage_in;
         out_k_ff    <= out_k_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      ar_ff     <= ar_in;
      ai_ff     <= ai_in;
      br_ff     <= br_in;
      bi_ff     <= bi_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      t_re_ff   <= t_re_in;
      t_im_ff   <= t_im_in;
   end

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("result offered while input is open");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_chan.last_bin) |=> (state_ff == wsfe_pkg::ST_IDLE))
      else $error("sequencer did not return to idle after last bin");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= wsfe_pkg::FILL_W'(FFT_POINTS))
      else $error("fill count beyond window");

   a_frame_step: assert property (@(posedge clock) disable iff (reset)
      (frame_ff != $past(frame_ff)) |-> $past(rsp_fire && rsp_chan.last_bin))
      else $error("frame number moved without a finished frame");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int N = 64;
   localparam int LOG2N = 6;
   localparam int STALL_MAX = 18;
   localparam int IDLE_LIMIT = 40000;
   localparam int RANDOM_ITEMS = 144;
   localparam int LONG_HOLD = 3000;
   localparam int DIR_ROWS = 22;

   typedef struct packed {
      logic [wsfe_pkg::FRAME_W-1:0]      frame_number;
      logic [wsfe_pkg::INDEX_W-1:0]      bin_index;
      logic signed [wsfe_pkg::BIN_W-1:0] bin_real;
      logic signed [wsfe_pkg::BIN_W-1:0] bin_imag;
      logic                              last_bin;
   } bin_type;

   // directed stimulus row; fixed expectation only where obvious
   typedef struct {
      logic signed [wsfe_pkg::SAMPLE_W-1:0] sample;
      int                                   run;     // repeat count
      bit                                   zero_chk; // frame of all-zero samples
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [wsfe_pkg::HOP_W-1:0] csr_wr_data = '0;

   wsfe_req_if req_chan();
   wsfe_rsp_if rsp_chan();

   windowed_stft_frame_engine #(.FFT_POINTS(N)) DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor tables and state
   longint win_rom [N];
   longint twr [N/2];
   longint twi [N/2];
   logic [wsfe_pkg::HOP_W-1:0]    hop_reg;
   logic [wsfe_pkg::SAMPLE_W-1:0] ring [64];
   int unsigned                   fill_cnt;
   int unsigned                   hop_cnt;
   logic [wsfe_pkg::RING_AW-1:0]  wr_ptr;
   logic [wsfe_pkg::FRAME_W-1:0]  frame_cnt;
   longint                        xr [N];
   longint                        xi [N];

   bin_type expected_bins [$];
   bit   zero_frame_due;
   int   mismatches = 0;
   bit   timed_out = 0;
   int   idle_cycles = 0;
   bit   hold_rx = 0;
   int   rx_wait;

   function automatic longint rnd_shift(longint v, int s);
      longint t;
      t = v + (longint'(1) << (s - 1));
      return t >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // cos(2*pi*p/q) in Q30 via Taylor series
   function automatic longint cos_q30(longint unsigned p, longint unsigned q);
      longint unsigned full, pos, r, x2, term;
      longint sum;
      bit neg;
      full = 4 * q;
      pos = (p * 4) % full;
      neg = 0;
      if (pos > 2 * q) pos = full - pos;
      if (pos > q) begin
         pos = 2 * q - pos;
         neg = 1;
      end
      r = longint'(wsfe_pkg::PI_HALF_Q30) * pos / q;
      x2 = (r * r) >> 30;
      term = 64'd1 << 30;
      sum = longint'(1) << 30;
      for (int k = 1; k <= 10; k++) begin
         term = (term * x2) >> 30;
         term = term / ((2 * k - 1) * (2 * k));
         if (k & 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      return neg ? -sum : sum;
   endfunction

   task automatic build_tables();
      longint c, v;
      for (int n = 0; n < N; n++) begin
         c = cos_q30(n, N - 1);
         v = (longint'(wsfe_pkg::C054_Q30) << 30) - longint'(wsfe_pkg::C046_Q30) * c;
         win_rom[n] = clamp(rnd_shift(v, 45), 0, 32767);
      end
      for (int n = 0; n < N/2; n++) begin
         twr[n] = clamp(rnd_shift(cos_q30(n, N), 15), -32768, 32767);
         twi[n] = clamp(rnd_shift(-cos_q30(4*n + 3*N, 4*N), 15), -32768, 32767);
      end
   endtask

   // windowed FFT over the last N samples; queue all bins
   task automatic predict_frame();
      int unsigned idx, d, half, stp, ia, ib, k;
      longint s, tr, ti, ar, ai, br, bi;
      bin_type b;
      for (int j = 0; j < N; j++) begin
         idx = (wr_ptr + 64 - N + j) & 63;
         s = longint'($signed(ring[idx]));
         d = 0;
         for (int t = 0; t < LOG2N; t++) d = (d << 1) | ((j >> t) & 1);
         xr[d] = rnd_shift(s * win_rom[j], 15);
         xi[d] = 0;
      end
      for (int len = 2; len <= N; len <<= 1) begin
         half = len / 2;
         stp = N / len;
         for (int st = 0; st < N; st += len) begin
            for (int i = 0; i < half; i++) begin
               ia = st + i;
               ib = st + i + half;
               k = i * stp;
               br = xr[ib]; bi = xi[ib]; ar = xr[ia]; ai = xi[ia];
               tr = rnd_shift(twr[k] * br - twi[k] * bi, 15);
               ti = rnd_shift(twr[k] * bi + twi[k] * br, 15);
               xr[ia] = clamp(ar + tr, -8388608, 8388607);
               xi[ia] = clamp(ai + ti, -8388608, 8388607);
               xr[ib] = clamp(ar - tr, -8388608, 8388607);
               xi[ib] = clamp(ai - ti, -8388608, 8388607);
            end
         end
      end
      for (int n = 0; n < N; n++) begin
         b.frame_number = frame_cnt;
         b.bin_index = wsfe_pkg::INDEX_W'(n);
         b.bin_real = wsfe_pkg::BIN_W'(xr[n]);
         b.bin_imag = wsfe_pkg::BIN_W'(xi[n]);
         b.last_bin = (n == N - 1);
         expected_bins.push_back(b);
      end
      frame_cnt = frame_cnt + 1'b1;
   endtask

   task automatic predict_sample(logic [wsfe_pkg::SAMPLE_W-1:0] smp);
      bit fire;
      fire = 0;
      ring[wr_ptr] = smp;
      wr_ptr = wr_ptr + 1'b1;
      if (fill_cnt < N) begin
         fill_cnt++;
         if (fill_cnt >= N) begin
            fire = 1;
            hop_cnt = hop_reg;
         end
      end else if (hop_cnt <= 1) begin
         fire = 1;
         hop_cnt = hop_reg;
      end else begin
         hop_cnt--;
      end
      if (fire) predict_frame();
   endtask

   // valid stays high into the next item unless a gap is drawn
   task automatic send_sample(logic signed [wsfe_pkg::SAMPLE_W-1:0] smp, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= smp;
      do @(posedge clock); while (!req_chan.ready);
      predict_sample(smp);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (expected_bins.size() != 0) @(posedge clock);
      repeat (2200) @(posedge clock);
   endtask

   task automatic write_hop(logic [wsfe_pkg::HOP_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hop_reg = v;
   endtask

   function automatic logic signed [wsfe_pkg::SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return wsfe_pkg::SAMPLE_W'($urandom_range(0, 64) - 32);
         default: return wsfe_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   // receiver: random stalls, plus one long hold-off
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_wait <= 0;
      end else if (hold_rx) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_chan.ready && rsp_chan.valid) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, STALL_MAX) : 0;
         rx_wait <= w;
         rsp_chan.ready <= (w == 0);
      end else if (rx_wait > 0) begin
         rx_wait <= rx_wait - 1;
         rsp_chan.ready <= (rx_wait == 1);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // compare each accepted bin against the oldest expectation
   always @(posedge clock) begin
      bin_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.frame_number = rsp_chan.frame_number;
         got.bin_index = rsp_chan.bin_index;
         got.bin_real = rsp_chan.bin_real;
         got.bin_imag = rsp_chan.bin_imag;
         got.last_bin = rsp_chan.last_bin;
         if (expected_bins.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected bin %p", got);
         end else begin
            want = expected_bins.pop_front();
            if (zero_frame_due && (want.bin_real != 0 || want.bin_imag != 0)) begin
               mismatches++;
               if (mismatches <= 10) $display("zero frame predicted nonzero %p", want);
            end
            if (want.last_bin) zero_frame_due = 0;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("bin mismatch exp %p act %p", want, got);
            end
         end
      end
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || hold_rx || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("FAIL");
         $finish;
      end
   end

   dir_row_type dir_tab [DIR_ROWS];

   initial begin
      int hop_pick;
      int hold_items;
      req_chan.valid = 1'b0;
      req_chan.sample = '0;
      build_tables();
      hop_reg = wsfe_pkg::HOP_RESET;
      fill_cnt = 0; hop_cnt = 0; wr_ptr = 0; frame_cnt = 0;
      zero_frame_due = 0;
      // first frame all zeros: every bin reads zero
      dir_tab[0] = '{16'sd0, 64, 1};
      dir_tab[1] = '{16'sh7fff, 32, 0};
      dir_tab[2] = '{16'sh8000, 32, 0};
      dir_tab[3] = '{16'sh7fff, 16, 0};
      dir_tab[4] = '{16'sh8000, 16, 0};
      for (int i = 5; i < DIR_ROWS; i++)
         dir_tab[i] = '{(i & 1) ? 16'sh7fff : 16'sh8000, 1, 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_tab[r].zero_chk) zero_frame_due = 1;
         if (r == 5) write_hop(9'd1);
         for (int n = 0; n < dir_tab[r].run; n++)
            send_sample(dir_tab[r].sample, r < 5 && n % 4 != 0);
      end

      // hop of zero behaves as one; long receiver hold-off while the sender keeps
      // offering items, which the engine refuses until the waiting frame is taken
      write_hop(9'd0);
      hold_items = int'(hop_cnt) + 3;
      hold_rx = 1;
      fork
         begin
            repeat (LONG_HOLD) @(posedge clock);
            hold_rx = 0;
         end
         repeat (hold_items) send_sample(rand_sample(), 1);
      join

      // random phases of different hop sizes
      for (int p = 0; p < 6; p++) begin
         hop_pick = $urandom_range(0, 3);
         write_hop(hop_pick == 0 ? 9'd64 : hop_pick == 1 ? 9'd1 :
                   wsfe_pkg::HOP_W'($urandom_range(2, 24)));
         for (int n = 0; n < RANDOM_ITEMS / 6; n++)
            send_sample(rand_sample(), $urandom_range(0, 3) == 0);
         // pause until all bins have come
         drain();
      end

      // hop above window: samples between frames skipped
      write_hop(9'd96);
      repeat (100) send_sample(rand_sample(), 1);
      write_hop(9'h1ff);
      repeat (10) send_sample(rand_sample(), 1);

      drain();
      if (mismatches == 0 && expected_bins.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
